@@ hdl/queue_based_signal_phase_picker_assert.svh @@
// Assertion helpers, clocked on clk_i and held off while rst_ni is low.
`ifndef QUEUE_BASED_SIGNAL_PHASE_PICKER_ASSERT_SVH
`define QUEUE_BASED_SIGNAL_PHASE_PICKER_ASSERT_SVH

// Same-cycle implication.
`define QBSPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QBSPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/qbspp_pkg.sv @@
package qbspp_pkg;

  localparam int LaneCount    = 8;
  localparam int PartnerCount = 3;
  localparam int PhaseBits    = 5;
  localparam int ArriveBits   = 8;

  typedef logic [2:0]           lane_idx_t;
  typedef logic [PhaseBits-1:0] phase_t;

  localparam phase_t PhaseIdle       = 5'd0;
  localparam phase_t PhaseSingleBase = 5'd13;

  // Compatible partners of each lane, in tie order.
  localparam lane_idx_t PartnerLane [LaneCount][PartnerCount] = '{
    '{3'd1, 3'd2, 3'd7}, '{3'd0, 3'd4, 3'd3}, '{3'd0, 3'd5, 3'd3}, '{3'd1, 3'd2, 3'd6},
    '{3'd1, 3'd5, 3'd6}, '{3'd2, 3'd4, 3'd7}, '{3'd3, 3'd4, 3'd7}, '{3'd0, 3'd5, 3'd6}
  };

  // Pair phase for each lane/partner combination.
  localparam phase_t PartnerPhase [LaneCount][PartnerCount] = '{
    '{5'd1, 5'd2, 5'd3},  '{5'd1, 5'd4, 5'd5},   '{5'd2, 5'd6, 5'd7},
    '{5'd5, 5'd7, 5'd8},  '{5'd4, 5'd9, 5'd10},  '{5'd6, 5'd9, 5'd11},
    '{5'd8, 5'd10, 5'd12}, '{5'd3, 5'd11, 5'd12}
  };

  // Decision handed from the merge stage back to the lanes and the output.
  typedef struct packed {
    phase_t               phase;
    logic [LaneCount-1:0] served;
  } pick_t;

endpackage

@@ hdl/qbspp_lane.sv @@
module qbspp_lane #(
  parameter int QUEUE_BITS = 16
) (
  input  logic [QUEUE_BITS-1:0]           count_i,
  input  logic [qbspp_pkg::ArriveBits-1:0] arrive_i,
  input  logic                            serve_i,
  output logic [QUEUE_BITS-1:0]           sum_o,
  output logic [QUEUE_BITS-1:0]           next_o
);

  localparam int SumBits =
    ((QUEUE_BITS > qbspp_pkg::ArriveBits) ? QUEUE_BITS : qbspp_pkg::ArriveBits) + 1;

  logic [SumBits-1:0] sum_wide;

  assign sum_wide = SumBits'(count_i) + SumBits'(arrive_i);

  // saturate at the counter maximum
  assign sum_o  = (|sum_wide[SumBits-1:QUEUE_BITS]) ? {QUEUE_BITS{1'b1}}
                                                    : sum_wide[QUEUE_BITS-1:0];
  // served lanes are always nonzero, so no underflow
  assign next_o = sum_o - QUEUE_BITS'(serve_i);

endmodule

@@ hdl/qbspp_merge.sv @@
module qbspp_merge #(
  parameter int QUEUE_BITS = 16
) (
  input  logic [qbspp_pkg::LaneCount-1:0][QUEUE_BITS-1:0] sum_i,
  output qbspp_pkg::pick_t                                pick_o
);

  logic [QUEUE_BITS-1:0]  val1 [4];
  qbspp_pkg::lane_idx_t   idx1 [4];
  logic [QUEUE_BITS-1:0]  val2 [2];
  qbspp_pkg::lane_idx_t   idx2 [2];
  logic [QUEUE_BITS-1:0]  top_val;
  qbspp_pkg::lane_idx_t   top_idx;
  qbspp_pkg::lane_idx_t   p0, p1, p2, best_lane;
  logic [1:0]             best_k;
  logic [QUEUE_BITS-1:0]  best_val;

  // argmax tree; the left side wins ties, so the lowest lane is kept
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (sum_i[2*k+1] > sum_i[2*k]) begin
        val1[k] = sum_i[2*k+1];
        idx1[k] = 3'(2*k+1);
      end else begin
        val1[k] = sum_i[2*k];
        idx1[k] = 3'(2*k);
      end
    end
    for (int k = 0; k < 2; k++) begin
      if (val1[2*k+1] > val1[2*k]) begin
        val2[k] = val1[2*k+1];
        idx2[k] = idx1[2*k+1];
      end else begin
        val2[k] = val1[2*k];
        idx2[k] = idx1[2*k];
      end
    end
    if (val2[1] > val2[0]) begin
      top_val = val2[1];
      top_idx = idx2[1];
    end else begin
      top_val = val2[0];
      top_idx = idx2[0];
    end
  end

  // fullest partner, first listed on a tie
  always_comb begin
    p0       = qbspp_pkg::PartnerLane[top_idx][0];
    p1       = qbspp_pkg::PartnerLane[top_idx][1];
    p2       = qbspp_pkg::PartnerLane[top_idx][2];
    best_k   = 2'd0;
    best_val = sum_i[p0];
    if (sum_i[p1] > best_val) begin
      best_k   = 2'd1;
      best_val = sum_i[p1];
    end
    if (sum_i[p2] > best_val) begin
      best_k   = 2'd2;
      best_val = sum_i[p2];
    end
    best_lane = qbspp_pkg::PartnerLane[top_idx][best_k];
  end

  always_comb begin
    pick_o.phase  = qbspp_pkg::PhaseIdle;
    pick_o.served = '0;
    if (top_val != '0) begin
      pick_o.served[top_idx] = 1'b1;
      if (best_val != '0) begin
        pick_o.served[best_lane] = 1'b1;
        pick_o.phase = qbspp_pkg::PartnerPhase[top_idx][best_k];
      end else begin
        pick_o.phase = qbspp_pkg::PhaseSingleBase
                     + qbspp_pkg::PhaseBits'(top_idx);
      end
    end
  end

endmodule

@@ hdl/queue_based_signal_phase_picker.sv @@
// Four-approach junction phase picker. Each transfer on the slave side carries
// one tick of arrivals for the eight lanes (straight and right-turn for A..D);
// the counters add them with saturation, the fullest lane is served together
// with its fullest compatible partner (lowest lane / first listed partner on
// ties, partner only if nonzero), and one result transfer per tick reports the
// phase, the four aspects and whether every queue is now empty. Throughput is
// one tick per clock while s_axis_tready is high: the loop through the
// counter registers (saturating add, 8-way max tree, partner compare,
// decrement) sets it. Each result is registered into the output buffer;
// its two entries (head plus skid) take one more tick while the master side
// stalls, and once both are full s_axis_tready drops until the head drains.
module queue_based_signal_phase_picker #(
  parameter int QUEUE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] arrive_a_straight, [15:8] arrive_a_right, [23:16] arrive_b_straight,
  // [31:24] arrive_b_right, [39:32] arrive_c_straight, [47:40] arrive_c_right,
  // [55:48] arrive_d_straight, [63:56] arrive_d_right
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [4:0] phase, [6:5] aspect_a, [8:7] aspect_b, [10:9] aspect_c,
  // [12:11] aspect_d, [13] all_empty, [15:14] zero
  output logic [15:0] m_axis_tdata
);

`include "queue_based_signal_phase_picker_assert.svh"

  localparam int Lanes = qbspp_pkg::LaneCount;

  logic [Lanes-1:0][QUEUE_BITS-1:0] cnt_q;
  logic [Lanes-1:0][QUEUE_BITS-1:0] sum;
  logic [Lanes-1:0][QUEUE_BITS-1:0] cnt_d;
  qbspp_pkg::pick_t                 pick;
  logic [13:0]                      result;
  logic                             push, pop;

  // output buffer: head drives the port, skid catches a transfer on stall
  logic        head_vld_q, skid_vld_q;
  logic [13:0] head_q, skid_q;

  assign push = s_axis_tvalid & s_axis_tready;
  assign pop  = m_axis_tvalid & m_axis_tready;

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    qbspp_lane #(
      .QUEUE_BITS(QUEUE_BITS)
    ) u_lane (
      .count_i (cnt_q[g]),
      .arrive_i(s_axis_tdata[8*g +: 8]),
      .serve_i (pick.served[g]),
      .sum_o   (sum[g]),
      .next_o  (cnt_d[g])
    );
  end

  qbspp_merge #(
    .QUEUE_BITS(QUEUE_BITS)
  ) u_merge (
    .sum_i (sum),
    .pick_o(pick)
  );

  // served bits map straight onto the aspect fields, two lanes per approach
  assign result = {(cnt_d == '0), pick.served, pick.phase};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (push) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!head_vld_q || pop) begin
      if (skid_vld_q) begin
        head_vld_q <= 1'b1;
        skid_vld_q <= push;
      end else begin
        head_vld_q <= push;
      end
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!head_vld_q || pop) begin
      if (skid_vld_q) begin
        head_q <= skid_q;
        skid_q <= result;
      end else begin
        head_q <= result;
      end
    end else if (push) begin
      skid_q <= result;
    end
  end

  assign s_axis_tready = !skid_vld_q;
  assign m_axis_tvalid = head_vld_q;
  assign m_axis_tdata  = {2'b00, head_q};

  `QBSPP_ASSERT_NOW(a_skid_needs_head, skid_vld_q, head_vld_q,
                    "skid entry held without a head entry")
  `QBSPP_ASSERT_NEXT(a_stall_fills_skid, head_vld_q && !m_axis_tready && push,
                     skid_vld_q, "transfer during output stall was not buffered")
  `QBSPP_ASSERT_NOW(a_idle_no_service, push,
                    (pick.phase == qbspp_pkg::PhaseIdle) == (pick.served == '0),
                    "idle phase disagrees with served lanes")
  `QBSPP_ASSERT_NOW(a_at_most_two, 1'b1, $countones(pick.served) <= 2,
                    "more than two lanes served")
  `QBSPP_ASSERT_NEXT(a_counts_hold, !push, $stable(cnt_q),
                     "queue counters changed without an input transfer")

endmodule

@@ test/testbench.sv @@
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int   QueueBits  = 16;
  localparam int   ClkPeriod  = 10;
  localparam int   ResetCycles = 11;
  // Cycles without any transfer before the run is called hung. The longest
  // legal quiet stretch is the output hold plus a few sender gaps.
  localparam int   StallLimit = 2000;
  localparam int   HoldCycles = 300;
  localparam int   IdlePct    = 17;
  localparam logic [QueueBits-1:0] QueueFull = {QueueBits{1'b1}};

  // Result word as it appears on m_axis_tdata, lowest field last.
  typedef struct packed {
    logic [1:0]        pad;
    logic              all_empty;
    logic [1:0]        aspect_d;
    logic [1:0]        aspect_c;
    logic [1:0]        aspect_b;
    logic [1:0]        aspect_a;
    qbspp_pkg::phase_t phase;
  } signal_word_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  // Shadow of the eight lane counters, lane 0 = A straight ... lane 7 = D right.
  logic [QueueBits-1:0] lane_cars [qbspp_pkg::LaneCount];
  signal_word_t         expected_signals [$];

  int           errors       = 0;
  int           quiet_cycles = 0;
  int           hold_request = 0;
  int           hold_left    = 0;
  bit           no_idle      = 1'b0;
  signal_word_t want;
  signal_word_t got;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  queue_based_signal_phase_picker #(
    .QUEUE_BITS(QueueBits)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  function automatic logic lanes_clear();
    logic clear;
    clear = 1'b1;
    for (int l = 0; l < qbspp_pkg::LaneCount; l++) begin
      if (lane_cars[l] != '0) clear = 1'b0;
    end
    return clear;
  endfunction

  // ---------------------------------------------------------------------------
  // Prediction: one junction tick. Arrivals saturate, the fullest lane (lowest
  // index on ties) goes, then its fullest partner (first listed on ties) if
  // that partner has a car. Served lanes lose one car.
  // ---------------------------------------------------------------------------
  function automatic signal_word_t serve_tick(input logic [63:0] arrivals);
    signal_word_t                    res;
    logic [qbspp_pkg::LaneCount-1:0] served;
    logic [QueueBits:0]              sum;
    int                              top;
    int                              pick;
    qbspp_pkg::lane_idx_t            mate;
    res    = '0;
    served = '0;
    top    = 0;
    for (int l = 0; l < qbspp_pkg::LaneCount; l++) begin
      sum = {1'b0, lane_cars[l]} + (QueueBits+1)'(arrivals[l*8 +: 8]);
      lane_cars[l] = sum[QueueBits] ? QueueFull : sum[QueueBits-1:0];
    end
    for (int l = 1; l < qbspp_pkg::LaneCount; l++) begin
      if (lane_cars[l] > lane_cars[top]) top = l;
    end
    if (lane_cars[top] == '0) begin
      // Empty junction: everybody stops.
      res.phase = qbspp_pkg::PhaseIdle;
    end else begin
      pick = 0;
      for (int k = 1; k < qbspp_pkg::PartnerCount; k++) begin
        if (lane_cars[qbspp_pkg::PartnerLane[top][k]] >
            lane_cars[qbspp_pkg::PartnerLane[top][pick]]) pick = k;
      end
      mate        = qbspp_pkg::PartnerLane[top][pick];
      served[top] = 1'b1;
      if (lane_cars[mate] != '0) begin
        served[mate] = 1'b1;
        res.phase    = qbspp_pkg::PartnerPhase[top][pick];
      end else begin
        // No partner has a car: the fullest lane runs alone.
        res.phase = qbspp_pkg::PhaseSingleBase + qbspp_pkg::phase_t'(top);
      end
      for (int l = 0; l < qbspp_pkg::LaneCount; l++) begin
        if (served[l]) lane_cars[l] = lane_cars[l] - QueueBits'(1);
      end
    end
    res.aspect_a  = served[1:0];
    res.aspect_b  = served[3:2];
    res.aspect_c  = served[5:4];
    res.aspect_d  = served[7:6];
    res.all_empty = lanes_clear();
    return res;
  endfunction

  // Light traffic: about one car per tick spread over the lanes, and now and
  // then a full-range burst on one lane so the upper arrival bits toggle.
  function automatic logic [63:0] light_traffic();
    logic [63:0] arrivals;
    arrivals = '0;
    for (int l = 0; l < qbspp_pkg::LaneCount; l++) begin
      if ($urandom_range(99) < 6) arrivals[l*8 +: 8] = 8'($urandom_range(1, 3));
    end
    if ($urandom_range(127) == 0)
      arrivals[$urandom_range(qbspp_pkg::LaneCount - 1)*8 +: 8] = 8'($urandom_range(255));
    return arrivals;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: random gaps before the item, then hold it until the transfer.
  // tvalid is only touched once per time step; after a transfer the next item
  // or the gap is set up in the very step of that transfer.
  // ---------------------------------------------------------------------------
  task automatic send_tick(input logic [63:0] arrivals);
    while (!no_idle && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= arrivals;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_signals.push_back(serve_tick(arrivals));
  endtask

  task automatic drain_queues();
    while (!lanes_clear()) send_tick('0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_empty_and_single_lanes();
    send_tick('0);
    for (int l = 0; l < qbspp_pkg::LaneCount; l++) send_tick(64'd1 << (8 * l));
  endtask

  task automatic test_ties_and_partners();
    // Every lane equal: lane 0 with its first partner, then ties down the line.
    send_tick(64'h01010101_01010101);
    drain_queues();
    // Lane 3 fullest, all three partners tied.
    send_tick(64'h00010000_02010100);
    drain_queues();
    // Lane 0 fullest, none of its partners has a car.
    send_tick(64'h00000000_01000003);
    drain_queues();
    // Lane 4 fullest, two partners tied above the third.
    send_tick(64'h00020203_00000100);
    drain_queues();
    // Alternating bit patterns on single lanes.
    send_tick(64'h00000000_0000AA00);
    send_tick(64'h00550000_00000000);
    drain_queues();
  endtask

  task automatic test_random_light();
    for (int n = 0; n < 600; n++) begin
      send_tick(light_traffic());
      if (n % 150 == 149) drain_queues();
    end
    drain_queues();
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    for (int n = 0; n < 150; n++) send_tick(light_traffic());
    drain_queues();
    no_idle = 1'b0;
  endtask

  // Receiver holds off while the sender keeps offering, so the output buffer
  // fills and s_axis_tready must drop.
  task automatic test_output_hold();
    hold_request = HoldCycles;
    for (int n = 0; n < 60; n++) send_tick(light_traffic());
    drain_queues();
  endtask

  // Heavy arrivals on every lane until all counters pin at full scale, then
  // a few ticks of maximum arrivals on top.
  task automatic test_saturation();
    logic [63:0] arrivals;
    for (int n = 0; n < 360; n++) begin
      for (int l = 0; l < qbspp_pkg::LaneCount; l++)
        arrivals[l*8 +: 8] = 8'($urandom_range(128, 255));
      send_tick(arrivals);
    end
    for (int n = 0; n < 20; n++) send_tick({8{8'hFF}});
  endtask

  // ---------------------------------------------------------------------------
  // Receiver ready: random idling, or a long hold counted here.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= no_idle || ($urandom_range(99) >= IdlePct);
    end
  end

  task automatic check_field(input string name, input logic [4:0] want_v,
                             input logic [4:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  // Result checker: every output transfer against the oldest expected word.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (expected_signals.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_signals.pop_front();
        check_field("phase", want.phase, got.phase);
        check_field("aspect_a", 5'(want.aspect_a), 5'(got.aspect_a));
        check_field("aspect_b", 5'(want.aspect_b), 5'(got.aspect_b));
        check_field("aspect_c", 5'(want.aspect_c), 5'(got.aspect_c));
        check_field("aspect_d", 5'(want.aspect_d), 5'(got.aspect_d));
        check_field("all_empty", 5'(want.all_empty), 5'(got.all_empty));
        check_field("pad", 5'(want.pad), 5'(got.pad));
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("queue_based_signal_phase_picker regression: fail");
      $finish;
    end
  end

  initial begin
    for (int l = 0; l < qbspp_pkg::LaneCount; l++) lane_cars[l] = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_and_single_lanes();
    test_ties_and_partners();
    test_random_light();
    test_back_to_back();
    test_output_hold();
    test_saturation();

    s_axis_tvalid <= 1'b0;
    while (expected_signals.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (errors == 0 && expected_signals.size() == 0) begin
      $display("queue_based_signal_phase_picker regression: pass");
    end else begin
      $display("queue_based_signal_phase_picker regression: fail");
    end
    $finish;
  end

endmodule
